// File: src/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants of the binary input qualifier: transaction
// payloads, configuration register set, register indexes and flag positions.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

    // default width of the elapsed tick counters
    localparam int TIMER_BITS_DEF = 24;

    // fixed field widths
    localparam int TICK_W  = 24;
    localparam int DELTA_W = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int FLAGS_W = 7;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FLAGS        = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ON_DELAY     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OFF_DELAY    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LOW_LIMIT    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_HIGH_LIMIT   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_DEP_EXPECTED = 3'd6;

    // flag bit positions
    localparam int FLG_INVERT     = 0;
    localparam int FLG_THR_INVERT = 1;
    localparam int FLG_EDGE_LO    = 2;
    localparam int FLG_EDGE_HI    = 3;
    localparam int FLG_DEP_EN     = 4;
    localparam int FLG_DEP_BOOL   = 5;
    localparam int FLG_OFF_LEVEL  = 6;

    // edge toggle modes
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    // input transaction (one poll)
    typedef struct packed {
        logic                     mode;
        logic                     level_in;
        logic signed [DATA_W-1:0] analog_value;
        logic signed [DATA_W-1:0] dep_reading;
        logic [DELTA_W-1:0]       tick_delta;
        logic                     force_write;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic level_out;
        logic write_strobe;
    } t_out_item;

    // configuration register set
    typedef struct packed {
        logic [FLAGS_W-1:0]       flags;
        logic [TICK_W-1:0]        debounce_ticks;
        logic [TICK_W-1:0]        on_delay_ticks;
        logic [TICK_W-1:0]        off_delay_ticks;
        logic signed [DATA_W-1:0] low_limit;
        logic signed [DATA_W-1:0] high_limit;
        logic signed [DATA_W-1:0] dep_expected;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/biq_timer.sv
// ----------------------------------------------------------------------------
// biq_timer
// Saturating elapsed tick counter with restart and expiry compare.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_timer #(
    parameter int TIMER_BITS = biq_pkg::TIMER_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [biq_pkg::DELTA_W-1:0] i_delta,
    input  wire logic                        i_restart,
    input  wire logic [biq_pkg::TICK_W-1:0]  i_ticks,
    output logic                             o_expired
);
    import biq_pkg::*;

    localparam int SUM_W = ((TIMER_BITS > DELTA_W) ? TIMER_BITS : DELTA_W) + 1;
    localparam int CMP_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;

    logic [TIMER_BITS-1:0] r_elapsed;
    logic [TIMER_BITS-1:0] n_elapsed;
    logic [SUM_W-1:0]      w_sum;
    logic [SUM_W-1:0]      w_max;
    logic [TIMER_BITS-1:0] w_sat;

    // saturating add of the poll's ticks, then optional restart
    always_comb begin
        w_sum     = SUM_W'(r_elapsed) + SUM_W'(i_delta);
        w_max     = SUM_W'({TIMER_BITS{1'b1}});
        w_sat     = (w_sum > w_max) ? {TIMER_BITS{1'b1}} : w_sum[TIMER_BITS-1:0];
        n_elapsed = i_restart ? '0 : w_sat;
        o_expired = CMP_W'(n_elapsed) >= CMP_W'(i_ticks);
    end

    // counter register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
        end else if (i_step) begin
            r_elapsed <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

// File: src/biq_core.sv
// ----------------------------------------------------------------------------
// biq_core
// Qualification chain for one poll: threshold, dependency check, debounce,
// on-delay, off-delay and edge toggle, with its one-bit state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_core #(
    parameter int TIMER_BITS = biq_pkg::TIMER_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire biq_pkg::t_in_item i_item,
    input  wire biq_pkg::t_cfg     i_cfg,
    output biq_pkg::t_out_item     o_res
);
    import biq_pkg::*;

    // state registers
    logic r_deb_last, r_deb_pausing, r_deb_level;
    logic r_on_last, r_on_level;
    logic r_off_last, r_off_level;
    logic r_edge_last, r_edge_toggle;
    logic r_out_level;

    logic n_deb_last, n_deb_pausing, n_deb_level;
    logic n_on_last, n_on_level;
    logic n_off_last, n_off_level;
    logic n_edge_last, n_edge_toggle;

    // chain signals
    logic       w_raw, w_match, w_qual, w_deb, w_on, w_off, w_edge;
    logic       w_deb_chg, w_deb_pause_now;
    logic       w_deb_restart, w_on_restart, w_off_restart;
    logic       w_deb_exp, w_on_exp, w_off_exp;
    logic       w_deb_en, w_on_en, w_off_en;
    logic [1:0] w_edge_mode;

    assign w_deb_en    = (i_cfg.debounce_ticks != '0);
    assign w_on_en     = (i_cfg.on_delay_ticks != '0);
    assign w_off_en    = (i_cfg.off_delay_ticks != '0);
    assign w_edge_mode = i_cfg.flags[FLG_EDGE_HI:FLG_EDGE_LO];

    // raw level: digital sample or hysteresis threshold
    always_comb begin
        if (i_item.mode) begin
            if ($signed(i_item.analog_value) <= $signed(i_cfg.low_limit)) begin
                w_raw = i_cfg.flags[FLG_THR_INVERT];
            end else if ($signed(i_item.analog_value) >= $signed(i_cfg.high_limit)) begin
                w_raw = !i_cfg.flags[FLG_THR_INVERT];
            end else begin
                w_raw = r_out_level;
            end
        end else begin
            w_raw = i_item.level_in;
        end
    end

    // dependency check, off level or optional inversion
    always_comb begin
        if (!i_cfg.flags[FLG_DEP_EN]) begin
            w_match = 1'b1;
        end else if (i_cfg.flags[FLG_DEP_BOOL]) begin
            w_match = ((i_item.dep_reading != '0) == (i_cfg.dep_expected != '0));
        end else begin
            w_match = (i_item.dep_reading == i_cfg.dep_expected);
        end
        if (!w_match) begin
            w_qual = i_cfg.flags[FLG_OFF_LEVEL];
        end else begin
            w_qual = w_raw ^ i_cfg.flags[FLG_INVERT];
        end
    end

    // debounce stage
    always_comb begin
        n_deb_last      = r_deb_last;
        n_deb_pausing   = r_deb_pausing;
        n_deb_level     = r_deb_level;
        w_deb_chg       = (w_qual != r_deb_last);
        w_deb_pause_now = r_deb_pausing | w_deb_chg;
        w_deb_restart   = w_deb_en && w_deb_chg && !r_deb_pausing;
        if (!w_deb_en) begin
            n_deb_level = w_qual;
        end else begin
            n_deb_last    = w_qual;
            n_deb_pausing = w_deb_pause_now;
            if (w_deb_pause_now && w_deb_exp) begin
                n_deb_level   = w_qual;
                n_deb_pausing = 1'b0;
            end
        end
        w_deb = n_deb_level;
    end

    // on-delay stage
    always_comb begin
        n_on_last    = r_on_last;
        n_on_level   = r_on_level;
        w_on_restart = w_on_en && w_deb && !r_on_last;
        if (!w_on_en) begin
            n_on_level = w_deb;
        end else begin
            n_on_last = w_deb;
            if (!w_deb || w_on_exp) begin
                n_on_level = w_deb;
            end
        end
        w_on = n_on_level;
    end

    // off-delay stage
    always_comb begin
        n_off_last    = r_off_last;
        n_off_level   = r_off_level;
        w_off_restart = w_off_en && !w_on && r_off_last;
        if (!w_off_en) begin
            n_off_level = w_on;
        end else begin
            n_off_last = w_on;
            if (w_on || w_off_exp) begin
                n_off_level = w_on;
            end
        end
        w_off = n_off_level;
    end

    // edge toggle stage
    always_comb begin
        n_edge_last   = r_edge_last;
        n_edge_toggle = r_edge_toggle;
        unique case (w_edge_mode)
            EDGE_RISE: begin
                n_edge_toggle = r_edge_toggle ^ (w_off && !r_edge_last);
                n_edge_last   = w_off;
                w_edge        = n_edge_toggle;
            end
            EDGE_FALL: begin
                n_edge_toggle = r_edge_toggle ^ (!w_off && r_edge_last);
                n_edge_last   = w_off;
                w_edge        = n_edge_toggle;
            end
            default: begin
                w_edge = w_off;
            end
        endcase
    end

    // result: the stored level always ends up equal to the chain output
    assign o_res.level_out    = w_edge;
    assign o_res.write_strobe = i_item.force_write || (w_edge != r_out_level);

    // stage timers
    biq_timer #(.TIMER_BITS(TIMER_BITS)) u_deb_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (i_step),
        .i_delta   (i_item.tick_delta),
        .i_restart (w_deb_restart),
        .i_ticks   (i_cfg.debounce_ticks),
        .o_expired (w_deb_exp)
    );

    biq_timer #(.TIMER_BITS(TIMER_BITS)) u_on_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (i_step),
        .i_delta   (i_item.tick_delta),
        .i_restart (w_on_restart),
        .i_ticks   (i_cfg.on_delay_ticks),
        .o_expired (w_on_exp)
    );

    biq_timer #(.TIMER_BITS(TIMER_BITS)) u_off_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (i_step),
        .i_delta   (i_item.tick_delta),
        .i_restart (w_off_restart),
        .i_ticks   (i_cfg.off_delay_ticks),
        .o_expired (w_off_exp)
    );

    // state update on each processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_last    <= 1'b0;
            r_deb_pausing <= 1'b0;
            r_deb_level   <= 1'b0;
            r_on_last     <= 1'b0;
            r_on_level    <= 1'b0;
            r_off_last    <= 1'b0;
            r_off_level   <= 1'b0;
            r_edge_last   <= 1'b0;
            r_edge_toggle <= 1'b0;
            r_out_level   <= 1'b0;
        end else if (i_step) begin
            r_deb_last    <= n_deb_last;
            r_deb_pausing <= n_deb_pausing;
            r_deb_level   <= n_deb_level;
            r_on_last     <= n_on_last;
            r_on_level    <= n_on_level;
            r_off_last    <= n_off_last;
            r_off_level   <= n_off_level;
            r_edge_last   <= n_edge_last;
            r_edge_toggle <= n_edge_toggle;
            r_out_level   <= w_edge;
        end
    end

    // no strobe means the delivered level repeats the stored one
    a_no_strobe_same_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !o_res.write_strobe |-> o_res.level_out == r_out_level)
        else $error("level changed without write strobe");

    // stored output level follows the delivered level
    a_out_level_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_out_level == $past(o_res.level_out))
        else $error("stored output level does not follow result");

    // with debounce off the debounce level follows its input at once
    a_deb_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !w_deb_en |=> r_deb_level == $past(w_qual))
        else $error("debounce bypass did not pass the level");

    // without an edge mode the off-delay output reaches the result
    a_edge_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_edge_mode != EDGE_RISE && w_edge_mode != EDGE_FALL |-> w_edge == w_off)
        else $error("edge stage altered level with no edge mode");

endmodule

`default_nettype wire

// File: src/binary_input_qualifier_core.sv
// ----------------------------------------------------------------------------
// binary_input_qualifier_core
// Poll-by-poll qualification of a binary input: threshold, dependency
// check, debounce, on/off delays and edge toggle, with a write strobe.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------
//  in       | sink      | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out      | source    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg      | sink      | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
//  One transaction per clock is sustained while the output is not stalled;
//  an accepted transaction is loaded into the input register, goes through
//  one pass of logic and is then loaded into the result register.
//  Synchronous active-low reset clears all state but the data registers;
//  configuration resets to dependency expectation 1, everything else 0.
//  A stall at the output holds the result register and, once the input
//  register is also full, back-pressures the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_input_qualifier_core #(
    parameter int TIMER_BITS = biq_pkg::TIMER_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire biq_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output biq_pkg::t_out_item              o_out_data,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [biq_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [biq_pkg::DATA_W-1:0] i_cfg_data
);
    import biq_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item w_res;
    logic      w_advance;
    logic      w_step;
    logic      w_accept;

    // pipeline control
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_advance;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flags           <= '0;
            r_cfg.debounce_ticks  <= '0;
            r_cfg.on_delay_ticks  <= '0;
            r_cfg.off_delay_ticks <= '0;
            r_cfg.low_limit       <= '0;
            r_cfg.high_limit      <= '0;
            r_cfg.dep_expected    <= DATA_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FLAGS:        r_cfg.flags           <= i_cfg_data[FLAGS_W-1:0];
                CFG_DEBOUNCE:     r_cfg.debounce_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_ON_DELAY:     r_cfg.on_delay_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_OFF_DELAY:    r_cfg.off_delay_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_LOW_LIMIT:    r_cfg.low_limit       <= i_cfg_data;
                CFG_HIGH_LIMIT:   r_cfg.high_limit      <= i_cfg_data;
                CFG_DEP_EXPECTED: r_cfg.dep_expected    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    // qualification chain
    biq_core #(.TIMER_BITS(TIMER_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire
